// ----- hdl/toet_pkg.sv -----
`default_nettype none
package toet_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int TIME_W   = YEAR_W + MONTH_W + DAY_W + HOUR_W + MINUTE_W;

  // Field offsets inside a packed item, year in the lowest bits.
  localparam int YEAR_LSB   = 0;
  localparam int MONTH_LSB  = YEAR_LSB + YEAR_W;
  localparam int DAY_LSB    = MONTH_LSB + MONTH_W;
  localparam int HOUR_LSB   = DAY_LSB + DAY_W;
  localparam int MINUTE_LSB = HOUR_LSB + HOUR_W;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  // Most significant member first: the packed vector compares lexicographically.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
  } time_t;

  typedef struct packed {
    logic ge;       // stored time >= probe time
    logic date_eq;  // same year, month and day
  } cmp_res_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BEYOND    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_REM_RD,
    S_REM_CMP,
    S_SHF_RD,
    S_SHF_WR,
    S_GET_DATA,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ----- hdl/time_ordered_entry_table_core.sv -----
`default_nettype none
// Channel   Dir  tdata (low bit up)                                  tuser
// s_axis    in   year, month, day, hour, minute, tag, position       op
// m_axis    out  count, out_year, out_month, out_day, out_hour,      status
//                out_minute, out_tag
//
// One item at a time. The table sits in a single memory (one write, one
// registered read per cycle), and every entry scanned for a place or a match
// goes through the shared time compare unit. Insert moves entries up from the
// top until the new entry's place is found (a full table is refused without
// touching the memory); remove scans from the bottom for the first entry of
// the same date, then moves the entries above it down; read fetches the entry
// at the position (refused without a fetch when it is beyond the count).
// Reset clears the count and the control state; the memory is not cleared,
// only entries below the count are ever used. s_axis_tready is high only in
// idle; a finished result waits in the output register while the next
// transfer is taken, and a stalled output holds the sequencer in its last step.
module time_ordered_entry_table_core
  import toet_pkg::*;
#(
  parameter int DEPTH    = 16,
  parameter int TAG_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // year, month, day, hour, minute, tag, position, zero fill
  input  logic [((TIME_W + TAG_BITS + $clog2(DEPTH) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic [OP_W-1:0]                                            s_axis_tuser, // op
  input  logic                                                       s_axis_tvalid,
  output logic                                                       s_axis_tready,
  // count, out_year, out_month, out_day, out_hour, out_minute, out_tag, zero fill
  output logic [(($clog2(DEPTH + 1) + TIME_W + TAG_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic [STATUS_W-1:0]                                        m_axis_tuser, // status
  output logic                                                       m_axis_tvalid,
  input  logic                                                       m_axis_tready
);

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ENTRY_W = TAG_BITS + TIME_W;
  localparam int TAG_LSB = TIME_W;
  localparam int POS_LSB = TIME_W + TAG_BITS;
  localparam int OUT_W   = CNT_W + ENTRY_W;
  localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8 - OUT_W;

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  time_t               in_time;
  logic [TAG_BITS-1:0] in_tag;
  logic [ADDR_W-1:0]   in_pos;
  logic                in_xfer;

  always_comb begin
    in_time.year   = s_axis_tdata[YEAR_LSB +: YEAR_W];
    in_time.month  = s_axis_tdata[MONTH_LSB +: MONTH_W];
    in_time.day    = s_axis_tdata[DAY_LSB +: DAY_W];
    in_time.hour   = s_axis_tdata[HOUR_LSB +: HOUR_W];
    in_time.minute = s_axis_tdata[MINUTE_LSB +: MINUTE_W];
    in_tag         = s_axis_tdata[TAG_LSB +: TAG_BITS];
    in_pos         = s_axis_tdata[POS_LSB +: ADDR_W];
  end

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  time_t               probe_q, probe_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    count_q, count_d;
  status_e             status_q, status_d;
  logic [ENTRY_W-1:0]  res_q, res_d;

  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;
  status_e             out_status_q, out_status_d;

  // Entry memory: {tag, time}, one write and one registered read per cycle.
  logic [ENTRY_W-1:0]  mem [DEPTH];
  logic [ENTRY_W-1:0]  rdata_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic [CNT_W-1:0]    idx_dec;
  logic [CNT_W-1:0]    idx_inc;
  logic [ENTRY_W-1:0]  new_entry;
  logic                out_free;
  cmp_res_t            cmp_res;
  time_t               res_time;

  assign idx_dec   = idx_q - CNT_W'(1);
  assign idx_inc   = idx_q + CNT_W'(1);
  assign new_entry = {tag_q, probe_q};
  assign out_free  = !out_valid_q || m_axis_tready;
  assign res_time  = time_t'(res_q[TIME_W-1:0]);

  // Shared compare unit: stored entry from the memory port against the probe.
  toet_cmp u_cmp (
    .stored_i (time_t'(rdata_q[TIME_W-1:0])),
    .probe_i  (probe_q),
    .res_o    (cmp_res)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (op_e'(s_axis_tuser))
            OP_INSERT: state_d = (count_q == CNT_W'(DEPTH)) ? S_DONE : S_INS_RD;
            OP_REMOVE: state_d = S_REM_RD;
            OP_READ:   state_d = (CNT_W'(in_pos) >= count_q) ? S_DONE : S_GET_DATA;
            default:   state_d = S_DONE;
          endcase
        end
      end
      S_INS_RD:   state_d = (idx_q == '0) ? S_DONE : S_INS_CMP;
      S_INS_CMP:  state_d = cmp_res.ge ? S_INS_RD : S_DONE;
      S_REM_RD:   state_d = (idx_q == count_q) ? S_DONE : S_REM_CMP;
      S_REM_CMP:  state_d = cmp_res.date_eq ? S_SHF_RD : S_REM_RD;
      S_SHF_RD:   state_d = (idx_inc >= count_q) ? S_DONE : S_SHF_WR;
      S_SHF_WR:   state_d = S_SHF_RD;
      S_GET_DATA: state_d = S_DONE;
      S_DONE:     state_d = out_free ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and memory controls
  // ---------------------------------------------------------------------------
  always_comb begin
    probe_d      = probe_q;
    tag_d        = tag_q;
    idx_d        = idx_q;
    count_d      = count_q;
    status_d     = status_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = idx_q[ADDR_W-1:0];
    mem_wdata    = rdata_q;
    mem_raddr    = idx_q[ADDR_W-1:0];
    s_axis_tready = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        mem_raddr     = in_pos;
        if (in_xfer) begin
          probe_d  = in_time;
          tag_d    = in_tag;
          res_d    = '0;
          status_d = ST_OK;
          unique case (op_e'(s_axis_tuser))
            OP_INSERT: begin
              idx_d = count_q;
              if (count_q == CNT_W'(DEPTH)) begin
                status_d = ST_FULL;
              end
            end
            OP_REMOVE: idx_d = '0;
            OP_READ: begin
              if (CNT_W'(in_pos) >= count_q) begin
                status_d = ST_BEYOND;
              end
            end
            default: ;
          endcase
        end
      end
      // walk down from the top; idx_q is the hole being filled
      S_INS_RD: begin
        mem_raddr = idx_dec[ADDR_W-1:0];
        if (idx_q == '0) begin
          mem_we    = 1'b1;
          mem_wdata = new_entry;
          count_d   = count_q + CNT_W'(1);
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (cmp_res.ge) begin
          mem_wdata = rdata_q;
          idx_d     = idx_dec;
        end else begin
          mem_wdata = new_entry;
          count_d   = count_q + CNT_W'(1);
        end
      end
      S_REM_RD: begin
        if (idx_q == count_q) begin
          status_d = ST_NOT_FOUND;
        end
      end
      S_REM_CMP: begin
        if (cmp_res.date_eq) begin
          res_d = rdata_q;
        end else begin
          idx_d = idx_inc;
        end
      end
      // close the gap: entry idx+1 moves to idx
      S_SHF_RD: begin
        mem_raddr = idx_inc[ADDR_W-1:0];
        if (idx_inc >= count_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      S_SHF_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_inc;
      end
      S_GET_DATA: res_d = rdata_q;
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          // count in the lowest bits, then the entry with year lowest, as on the input side
          out_data_d   = {res_q[TAG_LSB +: TAG_BITS], res_time.minute, res_time.hour,
                          res_time.day, res_time.month, res_time.year, count_q};
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q      <= probe_d;
    tag_q        <= tag_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    res_q        <= res_d;
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // ---------------------------------------------------------------------------
  // Output
  // ---------------------------------------------------------------------------
  if (OUT_PAD > 0) begin : g_pad
    assign m_axis_tdata = {{OUT_PAD{1'b0}}, out_data_q};
  end else begin : g_nopad
    assign m_axis_tdata = out_data_q;
  end
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tvalid = out_valid_q;

endmodule
`default_nettype wire

// ----- hdl/toet_cmp.sv -----
`default_nettype none
module toet_cmp
  import toet_pkg::*;
(
  input  time_t    stored_i,
  input  time_t    probe_i,
  output cmp_res_t res_o
);

  always_comb begin
    res_o.ge      = (stored_i >= probe_i);
    res_o.date_eq = (stored_i.year == probe_i.year) &&
                    (stored_i.month == probe_i.month) &&
                    (stored_i.day == probe_i.day);
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_time_ordered_entry_table_core.sv -----
`timescale 1ns / 1ps

module tb_time_ordered_entry_table_core;
  import toet_pkg::*;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int POS_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IN_USED  = TIME_W + TAG_BITS + POS_W;
  localparam int IN_W     = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_USED = CNT_W + TIME_W + TAG_BITS;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  // Result field offsets: count first, then the entry as packed on the input side.
  localparam int R_YEAR   = CNT_W + YEAR_LSB;
  localparam int R_MONTH  = CNT_W + MONTH_LSB;
  localparam int R_DAY    = CNT_W + DAY_LSB;
  localparam int R_HOUR   = CNT_W + HOUR_LSB;
  localparam int R_MINUTE = CNT_W + MINUTE_LSB;
  localparam int R_TAG    = CNT_W + TIME_W;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;  // selector with no operation

  localparam int WATCHDOG  = 5000;
  localparam int HOLD_AT   = 1400;
  localparam int HOLD_LEN  = 400;
  localparam int PHASE_LEN = 600;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    entry_t           ent;
    logic [POS_W-1:0] position;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
    entry_t              ent;
  } reply_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic [OP_W-1:0]     s_axis_tuser  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  time_ordered_entry_table_core #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_BITS)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Shadow table, kept in time order like the block's.
  entry_t   shadow_slots [DEPTH];
  int       shadow_count = 0;
  request_t pending_requests[$];
  reply_t   due_results[$];
  request_t offered;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int accepted_cnt  = 0;
  int fail_cnt      = 0;
  int hold_left     = 0;
  bit hold_used     = 1'b0;
  int quiet_cycles  = 0;

  function automatic logic [TIME_W-1:0] stamp_of(entry_t e);
    return {e.year, e.month, e.day, e.hour, e.minute};
  endfunction

  // Apply one operation to the shadow table and return the reply it should produce.
  function automatic reply_t apply_to_table(request_t rq);
    reply_t rp;
    int     at;
    int     i;
    bit     hit;
    rp  = '0;
    hit = 1'b0;
    case (rq.op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          rp.status = ST_FULL;
        end else begin
          at = shadow_count;
          for (i = 0; i < shadow_count; i++) begin
            // equal times: the newcomer goes in front
            if (!hit && stamp_of(shadow_slots[i]) >= stamp_of(rq.ent)) begin
              at  = i;
              hit = 1'b1;
            end
          end
          for (i = shadow_count; i > at; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[at] = rq.ent;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        at = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (!hit && shadow_slots[i].year == rq.ent.year &&
              shadow_slots[i].month == rq.ent.month && shadow_slots[i].day == rq.ent.day) begin
            at  = i;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          rp.status = ST_NOT_FOUND;
        end else begin
          rp.ent = shadow_slots[at];
          for (i = at; i + 1 < shadow_count; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_count--;
        end
      end
      OP_READ: begin
        if (rq.position >= shadow_count) rp.status = ST_BEYOND;
        else rp.ent = shadow_slots[rq.position];
      end
      default: ;  // spare selector: table untouched
    endcase
    rp.count = CNT_W'(shadow_count);
    return rp;
  endfunction

  function automatic request_t make_request(logic [OP_W-1:0] op, int year, int month, int day,
                                            int hour, int minute, int tag, int position);
    request_t rq;
    rq.op         = op;
    rq.ent.year   = YEAR_W'(year);
    rq.ent.month  = MONTH_W'(month);
    rq.ent.day    = DAY_W'(day);
    rq.ent.hour   = HOUR_W'(hour);
    rq.ent.minute = MINUTE_W'(minute);
    rq.ent.tag    = TAG_BITS'(tag);
    rq.position   = POS_W'(position);
    return rq;
  endfunction

  // Dates come mostly from a small pool so that removes find matches and times collide;
  // now and then a field spans its whole bit width.
  function automatic request_t random_request(int ins_pct, int rem_pct);
    request_t rq;
    int       r;
    r = $urandom_range(99);
    if (r < ins_pct) rq.op = OP_INSERT;
    else if (r < ins_pct + rem_pct) rq.op = OP_REMOVE;
    else if (r < 97) rq.op = OP_READ;
    else rq.op = OP_SPARE;
    rq.ent.year   = ($urandom_range(9) == 0) ? YEAR_W'($urandom_range(16383))
                                             : YEAR_W'(2020 + $urandom_range(1));
    rq.ent.month  = ($urandom_range(9) == 0) ? MONTH_W'($urandom_range(15))
                                             : MONTH_W'(1 + $urandom_range(1));
    rq.ent.day    = ($urandom_range(9) == 0) ? DAY_W'($urandom_range(31))
                                             : DAY_W'(1 + $urandom_range(1));
    rq.ent.hour   = ($urandom_range(7) == 0) ? HOUR_W'($urandom_range(31))
                                             : HOUR_W'($urandom_range(2));
    rq.ent.minute = ($urandom_range(7) == 0) ? MINUTE_W'($urandom_range(63))
                                             : MINUTE_W'($urandom_range(3));
    rq.ent.tag    = TAG_BITS'($urandom_range(65535));
    rq.position   = POS_W'($urandom_range(DEPTH - 1));
    return rq;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Sender: predicts on each accepted transfer, then offers the next queued request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_results.push_back(apply_to_table(offered));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = pending_requests.pop_front();
          s_axis_tdata  <= {{(IN_W - IN_USED){1'b0}}, offered.position, offered.ent.tag,
                            offered.ent.minute, offered.ent.hour, offered.ent.day,
                            offered.ent.month, offered.ent.year};
          s_axis_tuser  <= offered.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that lets the block back up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_used     <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_used && accepted_cnt >= HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_LEN;
      hold_used     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        fail_cnt++;
      end else begin
        reply_t want;
        want = due_results.pop_front();
        check_field("status", want.status, m_axis_tuser);
        check_field("count", want.count, m_axis_tdata[0 +: CNT_W]);
        check_field("out_year", want.ent.year, m_axis_tdata[R_YEAR +: YEAR_W]);
        check_field("out_month", want.ent.month, m_axis_tdata[R_MONTH +: MONTH_W]);
        check_field("out_day", want.ent.day, m_axis_tdata[R_DAY +: DAY_W]);
        check_field("out_hour", want.ent.hour, m_axis_tdata[R_HOUR +: HOUR_W]);
        check_field("out_minute", want.ent.minute, m_axis_tdata[R_MINUTE +: MINUTE_W]);
        check_field("out_tag", want.ent.tag, m_axis_tdata[R_TAG +: TAG_BITS]);
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int ph;
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (ph = 0; ph < 3; ph++) begin
      @(negedge clk_i);
      src_idle_pct  = (ph == 0) ? 15 : (ph == 1) ? 64 : 0;
      sink_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 15 : 0;
      if (ph == 0) begin
        // empty table: read, remove, spare selector
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_REMOVE, 2020, 1, 1, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SPARE, 0, 0, 0, 0, 0, 0, 0));
        // field extremes, including values out of calendar range
        pending_requests.push_back(make_request(OP_INSERT, 16383, 15, 31, 31, 63, 65535, 15));
        pending_requests.push_back(make_request(OP_INSERT, 0, 0, 0, 0, 0, 0, 0));
        // same time again: must land in front of the older one
        pending_requests.push_back(make_request(OP_INSERT, 16383, 15, 31, 31, 63, 4660, 0));
        pending_requests.push_back(make_request(OP_INSERT, 9999, 12, 31, 23, 59, 170, 0));
        pending_requests.push_back(make_request(OP_INSERT, 2020, 1, 1, 0, 0, 21845, 15));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 2));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 4));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 5));
        pending_requests.push_back(make_request(OP_READ, 16383, 15, 31, 31, 63, 65535, 15));
        // remove takes the earliest match of the date, i.e. the newer equal-time entry
        pending_requests.push_back(make_request(OP_REMOVE, 16383, 15, 31, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_REMOVE, 0, 0, 0, 31, 63, 65535, 15));
        pending_requests.push_back(make_request(OP_REMOVE, 0, 0, 1, 0, 0, 0, 0));
        pending_requests.push_back(make_request(OP_SPARE, 16383, 15, 31, 31, 63, 65535, 15));
        pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0));
      end
      // alternate fill-heavy and drain-heavy stretches so the table goes full and empty
      for (n = 0; n < PHASE_LEN; n++) begin
        if ((n / 50) % 2 == 0) pending_requests.push_back(random_request(72, 14));
        else pending_requests.push_back(random_request(18, 62));
      end
      while (pending_requests.size() != 0 || s_axis_tvalid || due_results.size() != 0)
        @(negedge clk_i);
    end

    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
